// ----- src/pdlr_pkg.sv -----
// Shared types and constants for the mono downmix linear resampler.
`default_nettype none
package pdlr_pkg;

    localparam logic [15:0] DEFAULT_RATE = 16'd44100;
    localparam int FRAC_SCALE = 1000;

    // Frame index width covers the largest permitted frame (2048 pairs).
    localparam int SRC_IDX_W = 11;
    // Output position whole part: frame index plus one rate quotient step.
    localparam int POS_W = SRC_IDX_W + 17;

    localparam int DIV_W = 32;
    localparam int CMD_DEPTH = 4;

    localparam int DEF_MAX_FRAME_SAMPLES = 1152;
    localparam int DEF_MAX_RATE_RATIO = 6;

    typedef struct packed {
        logic signed [15:0]   mono;
        logic signed [15:0]   prev_mono;
        logic [SRC_IDX_W-1:0] src_index;
        logic                 first;
        logic                 last;
        logic [15:0]          in_rate;
        logic [15:0]          out_rate;
    } cmd_t;

endpackage
`default_nettype wire

// ----- src/pdlr_front.sv -----
// Front end: accepts sample pairs, downmixes and tags them for the back end.
`default_nettype none
module pdlr_front #(
    parameter int MAX_FRAME_SAMPLES = pdlr_pkg::DEF_MAX_FRAME_SAMPLES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic signed [15:0]  s_left_sample,
    input  wire logic signed [15:0]  s_right_sample,
    input  wire logic [1:0]          s_channel_count,
    input  wire logic [15:0]         s_input_rate,
    input  wire logic                s_frame_last,
    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data,
    output logic                     push,
    output pdlr_pkg::cmd_t           push_data,
    input  wire logic                full
);
    import pdlr_pkg::*;

    localparam logic [SRC_IDX_W-1:0] LAST_IDX = SRC_IDX_W'(MAX_FRAME_SAMPLES - 1);

    logic [SRC_IDX_W-1:0] src_idx_reg, src_idx_next;
    logic signed [15:0]   prev_mono_reg;
    logic [15:0]          out_rate_reg;

    logic signed [16:0]   pair_sum;
    logic signed [16:0]   pair_half;
    logic signed [15:0]   mono;
    logic                 last;

    assign s_ready = !full;
    assign push    = s_valid && !full;

    // Stereo average truncates toward zero: bias negative sums by one.
    assign pair_sum  = 17'(s_left_sample) + 17'(s_right_sample);
    assign pair_half = (pair_sum + {16'b0, pair_sum[16]}) >>> 1;
    assign mono      = s_channel_count[1] ? pair_half[15:0] : s_left_sample;

    assign last = s_frame_last || (src_idx_reg >= LAST_IDX);

    always_comb begin
        push_data.mono      = mono;
        push_data.prev_mono = prev_mono_reg;
        push_data.src_index = src_idx_reg;
        push_data.first     = (src_idx_reg == '0);
        push_data.last      = last;
        push_data.in_rate   = (s_input_rate == '0) ? DEFAULT_RATE : s_input_rate;
        push_data.out_rate  = (out_rate_reg == '0) ? 16'd1 : out_rate_reg;
        src_idx_next        = last ? '0 : src_idx_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_idx_reg   <= '0;
            prev_mono_reg <= '0;
            out_rate_reg  <= DEFAULT_RATE;
        end else begin
            if (cfg_wr_en) begin
                out_rate_reg <= cfg_wr_data;
            end
            if (push) begin
                src_idx_reg   <= src_idx_next;
                prev_mono_reg <= mono;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/pdlr_cmd_queue.sv -----
// Short command queue between the front and back ends.
`default_nettype none
module pdlr_cmd_queue (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  pdlr_pkg::cmd_t push_data,
    output logic           full,
    input  wire logic      pop,
    output pdlr_pkg::cmd_t head,
    output logic           empty
);
    import pdlr_pkg::*;

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    cmd_t             slots_reg [CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(CMD_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/pdlr_divider.sv -----
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor.
`default_nettype none
module pdlr_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [pdlr_pkg::DIV_W-1:0] dividend,
    input  wire logic [15:0]                divisor,
    output logic                            done,
    output logic [pdlr_pkg::DIV_W-1:0]      quotient,
    output logic [15:0]                     remainder
);
    import pdlr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      dsr_reg;

    logic [16:0]      trial;
    logic             fits;

    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = (trial >= {1'b0, dsr_reg});
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/pdlr_back.sv -----
// Back end: walks output positions, interpolates and delivers results.
`default_nettype none
module pdlr_back #(
    parameter int MAX_RATE_RATIO = pdlr_pkg::DEF_MAX_RATE_RATIO
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  pdlr_pkg::cmd_t    head,
    input  wire logic         empty,
    output logic              pop,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic signed [15:0] m_mono_out,
    output logic              m_run_last,
    output logic              m_frame_done
);
    import pdlr_pkg::*;

    localparam int MAX_RESULTS = 2 * MAX_RATE_RATIO;
    localparam int N_W = $clog2(MAX_RESULTS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RSTART = 4'd1;
    localparam logic [3:0] S_RWAIT  = 4'd2;
    localparam logic [3:0] S_EVAL   = 4'd3;
    localparam logic [3:0] S_MUL2   = 4'd4;
    localparam logic [3:0] S_ISTART = 4'd5;
    localparam logic [3:0] S_IWAIT  = 4'd6;
    localparam logic [3:0] S_GOT    = 4'd7;
    localparam logic [3:0] S_FLUSH  = 4'd8;

    logic [3:0]           state_reg;

    logic signed [15:0]   cur_mono_reg, prev_mono_reg;
    logic [SRC_IDX_W-1:0] k_reg;
    logic                 last_reg;
    logic [15:0]          in_rate_reg, o_reg;
    logic [15:0]          q_reg, m_reg;
    logic [POS_W-1:0]     w_reg;
    logic [15:0]          r_reg;
    logic [N_W-1:0]       n_reg;
    logic                 pend_valid_reg;
    logic signed [15:0]   pend_val_reg;
    logic signed [15:0]   v_reg;
    logic signed [32:0]   prod_reg;
    logic signed [33:0]   sum_reg;
    logic                 neg_reg;
    logic                 flush_end_reg;

    logic                 out_valid_reg;
    logic signed [15:0]   out_mono_reg;
    logic                 out_run_last_reg;
    logic                 out_frame_done_reg;

    // Divider hookup
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quotient;
    logic [15:0]          div_remainder;

    logic                 slot_free;
    logic                 w_lt_k, w_eq_k, frac_small;
    logic [25:0]          r_scaled;
    logic [15:0]          o_minus_r;
    logic signed [32:0]   prod_a_next;
    logic signed [32:0]   prod_b;
    logic signed [33:0]   sum_next;
    logic [33:0]          sum_mag;
    logic [16:0]          r_step;
    logic [POS_W-1:0]     w_adv;
    logic [15:0]          r_adv;
    logic [15:0]          quo_low;

    pdlr_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (o_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign slot_free = !out_valid_reg || m_ready;
    assign pop       = (state_reg == S_IDLE) && !empty;

    assign w_lt_k     = (w_reg < POS_W'(k_reg));
    assign w_eq_k     = (w_reg == POS_W'(k_reg));
    assign r_scaled   = 26'(r_reg) * 26'(FRAC_SCALE);
    assign frac_small = (r_scaled <= 26'(o_reg));

    assign o_minus_r   = o_reg - r_reg;
    assign prod_a_next = prev_mono_reg * $signed({1'b0, o_minus_r});
    assign prod_b      = cur_mono_reg * $signed({1'b0, r_reg});
    assign sum_next    = 34'(prod_reg) + 34'(prod_b);
    assign sum_mag     = sum_reg[33] ? 34'(-sum_reg) : 34'(sum_reg);

    assign div_start    = (state_reg == S_RSTART) || (state_reg == S_ISTART);
    assign div_dividend = (state_reg == S_RSTART) ? DIV_W'(in_rate_reg) : sum_mag[DIV_W-1:0];

    // Position step: whole part by the rate quotient, remainder with carry
    assign r_step = 17'(r_reg) + 17'(m_reg);
    always_comb begin
        if (r_step >= 17'(o_reg)) begin
            r_adv = 16'(r_step - 17'(o_reg));
            w_adv = w_reg + POS_W'(q_reg) + 1'b1;
        end else begin
            r_adv = r_step[15:0];
            w_adv = w_reg + POS_W'(q_reg);
        end
    end

    assign quo_low = div_quotient[15:0];

    assign m_valid      = out_valid_reg;
    assign m_mono_out   = out_mono_reg;
    assign m_run_last   = out_run_last_reg;
    assign m_frame_done = out_frame_done_reg;

    // Payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (!empty) begin
                    cur_mono_reg  <= head.mono;
                    prev_mono_reg <= head.prev_mono;
                    k_reg         <= head.src_index;
                    last_reg      <= head.last;
                    if (head.first) begin
                        in_rate_reg <= head.in_rate;
                        o_reg       <= head.out_rate;
                    end
                end
            end
            S_RWAIT: begin
                if (div_done) begin
                    q_reg <= quo_low;
                    m_reg <= div_remainder;
                end
            end
            S_EVAL: begin
                prod_reg <= prod_a_next;
                v_reg    <= cur_mono_reg;
            end
            S_MUL2: begin
                sum_reg <= sum_next;
            end
            S_ISTART: begin
                neg_reg <= sum_reg[33];
            end
            S_IWAIT: begin
                if (div_done) begin
                    v_reg <= neg_reg ? -$signed(quo_low) : $signed(quo_low);
                end
            end
            default: begin
            end
        endcase
        if (state_reg == S_GOT && n_reg < N_W'(MAX_RESULTS)
                && (slot_free || !pend_valid_reg)) begin
            pend_val_reg <= v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            w_reg              <= '0;
            r_reg              <= '0;
            n_reg              <= '0;
            pend_valid_reg     <= 1'b0;
            flush_end_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_mono_reg       <= '0;
            out_run_last_reg   <= 1'b0;
            out_frame_done_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (!empty) begin
                        n_reg     <= '0;
                        state_reg <= head.first ? S_RSTART : S_EVAL;
                    end
                end
                S_RSTART: begin
                    state_reg <= S_RWAIT;
                end
                S_RWAIT: begin
                    if (div_done) begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_lt_k) begin
                        state_reg <= S_MUL2;
                    end else if (w_eq_k && (frac_small || last_reg)) begin
                        state_reg <= S_GOT;
                    end else if (pend_valid_reg) begin
                        flush_end_reg <= 1'b1;
                        state_reg     <= S_FLUSH;
                    end else begin
                        if (last_reg) begin
                            w_reg <= '0;
                            r_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_MUL2: begin
                    state_reg <= S_ISTART;
                end
                S_ISTART: begin
                    state_reg <= S_IWAIT;
                end
                S_IWAIT: begin
                    if (div_done) begin
                        state_reg <= S_GOT;
                    end
                end
                S_GOT: begin
                    if (n_reg >= N_W'(MAX_RESULTS)) begin
                        // Result beyond the per-pair cap: dropped, position still moves
                        w_reg     <= w_adv;
                        r_reg     <= r_adv;
                        state_reg <= S_EVAL;
                    end else if (slot_free || !pend_valid_reg) begin
                        if (pend_valid_reg) begin
                            out_valid_reg      <= 1'b1;
                            out_mono_reg       <= pend_val_reg;
                            out_run_last_reg   <= 1'b0;
                            out_frame_done_reg <= 1'b0;
                        end
                        pend_valid_reg <= 1'b1;
                        n_reg          <= n_reg + 1'b1;
                        w_reg          <= w_adv;
                        r_reg          <= r_adv;
                        if (n_reg == N_W'(MAX_RESULTS - 1)) begin
                            flush_end_reg <= 1'b0;
                            state_reg     <= S_FLUSH;
                        end else begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_FLUSH: begin
                    if (slot_free) begin
                        out_valid_reg      <= 1'b1;
                        out_mono_reg       <= pend_val_reg;
                        out_run_last_reg   <= 1'b1;
                        out_frame_done_reg <= last_reg;
                        pend_valid_reg     <= 1'b0;
                        if (flush_end_reg) begin
                            if (last_reg) begin
                                w_reg <= '0;
                                r_reg <= '0;
                            end
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- src/pcm_downmix_linear_resampler.sv -----
// Top level of the mono downmix linear-interpolation resampler.
// Usage:
//  - Input channel (s_*): one stereo or mono sample pair per transaction, with
//    the frame's channel count, input rate (0 = 44100 Hz) and a last-of-frame flag.
//  - Result channel (m_*): resampled mono samples; m_run_last marks the final
//    result of one input transaction, m_frame_done the final result of a frame.
//  - cfg_wr_en/cfg_wr_data set the output rate (reset 44100 Hz); it is taken
//    up at the start of the next frame. Write only while the block is idle.
// Timing:
//  - Input pairs pass through a four-entry command queue, so the front end
//    keeps taking transactions while the back end is busy.
//  - The back end walks output positions one at a time. A result that falls
//    on a sample needs no division; an interpolated one waits on the shared
//    radix-2 divider. The first pair of a frame adds the rate ratio division,
//    on the same divider.
//  - Each result is held back until the next is known, so m_run_last can be
//    set.
//  - At most 2*MAX_RATE_RATIO results per pair; further ones are dropped.
// Reset: synchronous, active low; clears the queue, the position and the
// output register. A stalled m_ready holds the output and then the back end;
// once the queue fills, s_ready drops.
`default_nettype none
module pcm_downmix_linear_resampler #(
    parameter int MAX_FRAME_SAMPLES = pdlr_pkg::DEF_MAX_FRAME_SAMPLES,
    parameter int MAX_RATE_RATIO    = pdlr_pkg::DEF_MAX_RATE_RATIO
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic signed [15:0]  s_left_sample,
    input  wire logic signed [15:0]  s_right_sample,
    input  wire logic [1:0]          s_channel_count,
    input  wire logic [15:0]         s_input_rate,
    input  wire logic                s_frame_last,
    // result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [15:0]       m_mono_out,
    output logic                     m_run_last,
    output logic                     m_frame_done,
    // output rate register
    input  wire logic                cfg_wr_en,
    input  wire logic [15:0]         cfg_wr_data
);
    import pdlr_pkg::*;

    logic push, full, pop, empty;
    cmd_t push_data, head;

    // Front end: downmix, frame index, output rate register
    pdlr_front #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_left_sample   (s_left_sample),
        .s_right_sample  (s_right_sample),
        .s_channel_count (s_channel_count),
        .s_input_rate    (s_input_rate),
        .s_frame_last    (s_frame_last),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .push            (push),
        .push_data       (push_data),
        .full            (full)
    );

    // Decoupling queue
    pdlr_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // Back end: position walk, interpolation, result delivery
    pdlr_back #(
        .MAX_RATE_RATIO (MAX_RATE_RATIO)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_mono_out   (m_mono_out),
        .m_run_last   (m_run_last),
        .m_frame_done (m_frame_done)
    );

endmodule
`default_nettype wire
